### design/ltcs_pkg.sv
// ----------------------------------------------------------------------------
// ltcs_pkg
// Widths, fixed-point constants and reset values of the logistic-tent
// chaotic sequence generator.
// ----------------------------------------------------------------------------
package ltcs_pkg;

    // value and state: unsigned Q0.32, gain: unsigned Q3.30
    localparam int FRAC_W    = 32;
    localparam int GAIN_W    = 33;
    localparam int GAIN_FRAC = 30;

    // serial multiplier: multiplier digit and digits per product
    localparam int DIGIT_W = 8;
    localparam int DIGITS  = FRAC_W / DIGIT_W;
    localparam int CNT_W   = $clog2(DIGITS);
    localparam int SUM_W   = GAIN_W + DIGIT_W;
    localparam int PROD_W  = GAIN_W + FRAC_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 1'b1;

    localparam logic [GAIN_W-1:0] GAIN_FOUR  = GAIN_W'(64'h1_0000_0000);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(64'd4293893554);
    localparam logic [FRAC_W-1:0] SEED_RESET = FRAC_W'(64'd528280977);

endpackage

### design/ltcs_in_if.sv
// ----------------------------------------------------------------------------
// ltcs_in_if
// Tick channel: valid/ready handshake carrying the restart flag.
// ----------------------------------------------------------------------------
interface ltcs_in_if;

    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);

endinterface

### design/ltcs_out_if.sv
// ----------------------------------------------------------------------------
// ltcs_out_if
// Sample channel: valid/ready handshake carrying one sequence element.
// ----------------------------------------------------------------------------
interface ltcs_out_if;
    import ltcs_pkg::*;

    logic              valid;
    logic              ready;
    logic [FRAC_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);

endinterface

### design/logistic_tent_chaotic_sequence.sv
// ----------------------------------------------------------------------------
// logistic_tent_chaotic_sequence
// Fixed-point logistic-tent map: x' = frac(r*x*(1-x) + (4-r)*y/2), with
// three products on one digit-serial shift-add multiplier.
// ----------------------------------------------------------------------------
//   channel  | dir | payload              | beat
//   ---------+-----+----------------------+----------------------------
//   tick     | in  | restart (1 bit)      | valid & ready
//   sample   | out | value (32 bit Q0.32) | valid & ready
//   cfg      | in  | cfg_index, cfg_wdata | cfg_we, no back-pressure
//
// restart beat: seed goes into the state register, then into the output
//   register from the output state once sample is free.
// step beat: 3 products over 8-bit multiplier digits (one 33x8 multiply-add
//   per cycle), then the output state.
// tick is ready only in idle, even if sample is stalled;
// a finished value then waits in the state register until sample frees up.
// reset clears state to zero and loads gain and seed with their defaults.
// ----------------------------------------------------------------------------
module logistic_tent_chaotic_sequence (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ltcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ltcs_pkg::GAIN_W-1:0]      cfg_wdata,
    ltcs_in_if.sink                          tick,
    ltcs_out_if.source                       sample
);
    import ltcs_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL_T2 = 3'd1;
    localparam logic [2:0] ST_MUL_P = 3'd2;
    localparam logic [2:0] ST_MUL_T1 = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIGITS - 1);

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [FRAC_W-1:0] out_value_reg, out_value_next;
    logic [FRAC_W-1:0] x_reg, x_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [FRAC_W-1:0] seed_reg, seed_next;

    logic [GAIN_W-1:0] mcand_reg, mcand_next;
    logic [FRAC_W-1:0] mplier_reg, mplier_next;
    logic [GAIN_W-1:0] acc_reg, acc_next;
    logic [FRAC_W-1:0] lo_reg, lo_next;
    logic [FRAC_W-1:0] term2_reg, term2_next;

    logic [SUM_W-1:0]  pp;
    logic [SUM_W-1:0]  sum;
    logic [GAIN_W-1:0] acc_step;
    logic [FRAC_W-1:0] lo_step;
    logic [PROD_W-1:0] prod;
    logic [GAIN_W-1:0] x_omx;
    logic [GAIN_W-1:0] four_minus_r;
    logic [FRAC_W-1:0] y;
    logic [FRAC_W-1:0] new_value;
    logic              tick_beat;
    logic              sample_free;
    logic              mul_busy;
    logic              mul_last;

    // one multiplier digit per cycle, low product bits shift out into lo
    always_comb
    begin
        pp       = {{DIGIT_W{1'b0}}, mcand_reg} * {{GAIN_W{1'b0}}, mplier_reg[DIGIT_W-1:0]};
        sum      = {{DIGIT_W{1'b0}}, acc_reg} + pp;
        acc_step = sum[SUM_W-1:DIGIT_W];
        lo_step  = {sum[DIGIT_W-1:0], lo_reg[FRAC_W-1:DIGIT_W]};
        prod     = {acc_step, lo_step};
    end

    assign x_omx        = GAIN_FOUR - {1'b0, x_reg};
    assign four_minus_r = GAIN_FOUR - gain_reg;
    // x = 0.5 takes the 1-x branch, same y either way
    assign y            = x_reg[FRAC_W-1] ? x_omx[FRAC_W-1:0] : x_reg;
    // term1 = (r*p) >> 30, only its fraction matters
    assign new_value    = prod[FRAC_W+GAIN_FRAC-1:GAIN_FRAC] + term2_reg;

    assign tick_beat   = tick.valid && tick.ready;
    assign sample_free = !out_valid_reg || sample.ready;
    assign mul_busy    = (state_reg == ST_MUL_T2) || (state_reg == ST_MUL_P)
                         || (state_reg == ST_MUL_T1);
    assign mul_last    = mul_busy && (cnt_reg == CNT_LAST);

    assign tick.ready   = (state_reg == ST_IDLE);
    assign sample.valid = out_valid_reg;
    assign sample.value = out_value_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        x_next         = x_reg;
        gain_next      = gain_reg;
        seed_next      = seed_reg;
        mcand_next     = mcand_reg;
        mplier_next    = mplier_reg;
        acc_next       = acc_reg;
        lo_next        = lo_reg;
        term2_next     = term2_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GAIN: gain_next = (cfg_wdata > GAIN_FOUR) ? GAIN_FOUR : cfg_wdata;
                CFG_SEED: seed_next = cfg_wdata[FRAC_W-1:0];
                default:  ;
            endcase
        end

        if (sample.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (mul_busy)
        begin
            acc_next    = acc_step;
            lo_next     = lo_step;
            mplier_next = mplier_reg >> DIGIT_W;
            cnt_next    = cnt_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (tick_beat)
                begin
                    if (tick.restart)
                    begin
                        x_next     = seed_reg;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        mcand_next  = four_minus_r;
                        mplier_next = y;
                        acc_next    = '0;
                        cnt_next    = '0;
                        state_next  = ST_MUL_T2;
                    end
                end
            end
            ST_MUL_T2:
            begin
                if (mul_last)
                begin
                    // term2 = ((4-r)*y) >> 31
                    term2_next  = prod[FRAC_W+FRAC_W-2:FRAC_W-1];
                    mcand_next  = x_omx;
                    mplier_next = x_reg;
                    acc_next    = '0;
                    state_next  = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                if (mul_last)
                begin
                    // p = (x*(1-x)) >> 32
                    mcand_next  = gain_reg;
                    mplier_next = prod[PROD_W-2:FRAC_W];
                    acc_next    = '0;
                    state_next  = ST_MUL_T1;
                end
            end
            ST_MUL_T1:
            begin
                if (mul_last)
                begin
                    x_next     = new_value;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (sample_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = x_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            gain_reg      <= GAIN_RESET;
            seed_reg      <= SEED_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            gain_reg      <= gain_next;
            seed_reg      <= seed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        mcand_reg     <= mcand_next;
        mplier_reg    <= mplier_next;
        acc_reg       <= acc_next;
        lo_reg        <= lo_next;
        term2_reg     <= term2_next;
    end

    a_gain_sat: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= GAIN_FOUR)
        else $error("gain register above four");

    a_restart_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_beat && tick.restart) |=> (x_reg == $past(seed_reg)) && (state_reg == ST_OUT))
        else $error("restart beat did not load the seed");

    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_beat && !tick.restart) |=> (state_reg == ST_MUL_T2) && (cnt_reg == '0))
        else $error("step beat did not start the multiplier");

    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !mul_busy |-> (cnt_reg == '0))
        else $error("digit counter running outside a product");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && sample_free) |=> sample.valid && (sample.value == $past(x_reg)))
        else $error("finished value not moved to the output register");

endmodule
